// ===== sv/clcd_pkg.sv =====
// Shared types, constants and lookup functions for the character-LCD expander sequencer.
`default_nettype none
package clcd_pkg;

    localparam int DEF_READING_DIGITS = 5;
    localparam int READING_W = 16;
    localparam int INIT_CMDS = 6;
    localparam int TEXT_BYTES = 6;

    localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
    localparam logic [7:0] BIT_ENABLE = 8'h04;
    localparam logic [7:0] BIT_SELECT = 8'h01;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] CMD_LINE1 = 8'h80;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [31:0] RECIP_TEN = 32'd52429;
    localparam int RECIP_SHIFT = 19;

    localparam logic [1:0] PAUSE_SHORT = 2'd0;
    localparam logic [1:0] PAUSE_CHAR = 2'd1;
    localparam logic [1:0] PAUSE_CLEAR = 2'd2;

    localparam logic [2:0] ADDR_BACKLIGHT = 3'd0;

    typedef enum logic [1:0] {
        OP_CMD     = 2'd0,
        OP_DATA    = 2'd1,
        OP_INIT    = 2'd2,
        OP_READING = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CONV,
        SEQ_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        DIG_IDLE,
        DIG_MUL,
        DIG_SUB
    } dig_state_t;

    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic [1:0] final_pause;
        logic       last;
    } byte_req_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h33;
            3'd1: c = 8'h32;
            3'd2: c = 8'h28;
            3'd3: c = 8'h0C;
            3'd4: c = 8'h06;
            3'd5: c = 8'h01;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] gas_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h47;
            3'd1: c = 8'h41;
            3'd2: c = 8'h53;
            3'd3: c = 8'h3A;
            3'd4: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/clcd_div10_unit.sv =====
// Iterative decimal digit extractor built around one shared reciprocal multiplier.
`default_nettype none
module clcd_div10_unit
    import clcd_pkg::*;
#(
    parameter int READING_DIGITS = DEF_READING_DIGITS,
    parameter int CNT_W = $clog2(READING_DIGITS + 1),
    parameter int IDX_W = (READING_DIGITS > 1) ? $clog2(READING_DIGITS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [READING_W-1:0] value,
    input  wire logic [IDX_W-1:0]     rd_idx,
    output logic [3:0]                rd_digit,
    output logic                      busy,
    output logic [CNT_W-1:0]          count
);

    dig_state_t state_reg, state_next;
    logic [READING_W-1:0] val_reg;
    logic [31:0] prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [3:0] digit_mem [READING_DIGITS];

    logic [READING_W-1:0] quot;
    logic [READING_W-1:0] quot_ten;
    logic [3:0] rem;
    logic [CNT_W-1:0] cnt_inc;

    assign quot = READING_W'(prod_reg >> RECIP_SHIFT);
    assign quot_ten = READING_W'({quot, 3'b000}) + READING_W'({quot, 1'b0});
    assign rem = 4'(val_reg - quot_ten);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIG_IDLE: begin
                if (start) begin
                    state_next = DIG_MUL;
                end
            end
            DIG_MUL: state_next = DIG_SUB;
            DIG_SUB: begin
                if ((quot != '0) && (cnt_inc < CNT_W'(READING_DIGITS))) begin
                    state_next = DIG_MUL;
                end else begin
                    state_next = DIG_IDLE;
                end
            end
            default: state_next = DIG_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg)
            DIG_IDLE: busy = 1'b0;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIG_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == DIG_IDLE) && start) begin
                cnt_reg <= '0;
            end else if (state_reg == DIG_SUB) begin
                cnt_reg <= cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == DIG_IDLE) && start) begin
            val_reg <= value;
        end else if (state_reg == DIG_SUB) begin
            val_reg <= quot;
        end
        if (state_reg == DIG_MUL) begin
            prod_reg <= 32'(val_reg) * RECIP_TEN;
        end
        if (state_reg == DIG_SUB) begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= rem;
        end
    end

    assign rd_digit = digit_mem[rd_idx];
    assign count = cnt_reg;

endmodule
`default_nettype wire

// ===== sv/clcd_beat_gen.sv =====
// Splits one LCD byte into four expander beats and holds them in the output register.
`default_nettype none
module clcd_beat_gen
    import clcd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       backlight,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire byte_req_t  req,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic busy_reg;
    logic [1:0] phase_reg;
    byte_req_t req_reg;
    logic valid_reg;
    logic [7:0] data_reg;
    logic [1:0] pause_reg;
    logic last_reg;

    logic advance;
    logic [7:0] base;
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
    logic [7:0] beat_data;
    logic [1:0] beat_pause;
    logic beat_last;

    assign advance = busy_reg && (!valid_reg || m_tready);
    assign req_ready = !busy_reg || (advance && (phase_reg == 2'd3));

    assign base = (backlight ? BIT_BACKLIGHT : 8'h00) | (req_reg.is_data ? BIT_SELECT : 8'h00);
    assign hi_byte = (req_reg.value & NIBBLE_MASK) | base;
    assign lo_byte = ({req_reg.value[3:0], 4'b0000}) | base;

    always_comb begin
        beat_pause = PAUSE_SHORT;
        beat_last = 1'b0;
        case (phase_reg)
            2'd0: beat_data = hi_byte | BIT_ENABLE;
            2'd1: beat_data = hi_byte;
            2'd2: beat_data = lo_byte | BIT_ENABLE;
            2'd3: begin
                beat_data = lo_byte;
                beat_pause = req_reg.final_pause;
                beat_last = req_reg.last;
            end
            default: beat_data = lo_byte;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            phase_reg <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (req_valid && req_ready) begin
                busy_reg <= 1'b1;
                phase_reg <= 2'd0;
            end else if (advance) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
            if (advance) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_valid && req_ready) begin
            req_reg <= req;
        end
        if (advance) begin
            data_reg <= beat_data;
            pause_reg <= beat_pause;
            last_reg <= beat_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;
    assign m_tuser = pause_reg;
    assign m_tlast = last_reg;

endmodule
`default_nettype wire

// ===== sv/char_lcd_4bit_i2c_sequencer_top.sv =====
// Top level: request sequencer, digit conversion, beat generation and register port.
// Each request yields four beats per LCD byte: 4, 24 or 24 + 4 * digits (up to 44) beats.
// A show-reading request first passes through the shared divide-by-ten unit, a multiply and a subtract step per digit.
// Without back-pressure, beats leave at one per cycle.
// s_tready is high only while the sequencer is idle; the next request enters once the
// final byte has been handed to the beat generator.
// aresetn is synchronous and active low; it sets backlight_reg to 1 and empties all stages.
`default_nettype none
module char_lcd_4bit_i2c_sequencer_top
    import clcd_pkg::*;
#(
    parameter int READING_DIGITS = DEF_READING_DIGITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] opcode, [9:2] byte_value, [25:10] reading, [31:26] zero
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] expander_byte
    output logic [7:0]       m_tdata,
    // [1:0] pause_after
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(READING_DIGITS + 1);
    localparam int IDX_W = (READING_DIGITS > 1) ? $clog2(READING_DIGITS) : 1;
    localparam int BIDX_W = $clog2(TEXT_BYTES + READING_DIGITS + 1);

    seq_state_t state_reg, state_next;
    opcode_t op_reg;
    logic [7:0] byte_reg;
    logic [BIDX_W-1:0] bidx_reg;
    logic backlight_reg;

    logic s_accept;
    logic dig_busy;
    logic [CNT_W-1:0] dig_count;
    logic [3:0] dig_value;
    logic [BIDX_W-1:0] total_bytes;
    logic [BIDX_W-1:0] dig_pos;
    logic req_valid;
    logic req_ready;
    byte_req_t req;

    assign pready = 1'b1;
    assign prdata = {31'b0, (paddr == ADDR_BACKLIGHT) ? backlight_reg : 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backlight_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_BACKLIGHT)) begin
            backlight_reg <= pwdata[0];
        end
    end

    assign s_accept = s_tvalid && s_tready;

    clcd_div10_unit #(
        .READING_DIGITS(READING_DIGITS),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W)
    ) u_div10 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept && (opcode_t'(s_tdata[1:0]) == OP_READING)),
        .value   (s_tdata[25:10]),
        .rd_idx  (dig_pos[IDX_W-1:0]),
        .rd_digit(dig_value),
        .busy    (dig_busy),
        .count   (dig_count)
    );

    assign dig_pos = BIDX_W'(dig_count) + BIDX_W'(TEXT_BYTES - 1) - bidx_reg;

    always_comb begin
        case (op_reg)
            OP_CMD, OP_DATA: total_bytes = BIDX_W'(1);
            OP_INIT:         total_bytes = BIDX_W'(INIT_CMDS);
            OP_READING:      total_bytes = BIDX_W'(TEXT_BYTES) + BIDX_W'(dig_count);
            default:         total_bytes = BIDX_W'(1);
        endcase
    end

    always_comb begin
        req.value = byte_reg;
        req.is_data = 1'b0;
        req.final_pause = PAUSE_CHAR;
        req.last = (bidx_reg == total_bytes - BIDX_W'(1));
        case (op_reg)
            OP_CMD: req.value = byte_reg;
            OP_DATA: req.is_data = 1'b1;
            OP_INIT: begin
                req.value = init_cmd(bidx_reg[2:0]);
                if (bidx_reg == BIDX_W'(INIT_CMDS - 1)) begin
                    req.final_pause = PAUSE_CLEAR;
                end
            end
            OP_READING: begin
                if (bidx_reg == '0) begin
                    req.value = CMD_LINE1;
                end else if (bidx_reg < BIDX_W'(TEXT_BYTES)) begin
                    req.is_data = 1'b1;
                    req.value = gas_char(3'(bidx_reg - BIDX_W'(1)));
                end else begin
                    req.is_data = 1'b1;
                    req.value = CHAR_ZERO | {4'b0000, dig_value};
                end
            end
            default: req.value = byte_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (s_accept) begin
                    if (opcode_t'(s_tdata[1:0]) == OP_READING) begin
                        state_next = SEQ_CONV;
                    end else begin
                        state_next = SEQ_EMIT;
                    end
                end
            end
            SEQ_CONV: begin
                if (!dig_busy) begin
                    state_next = SEQ_EMIT;
                end
            end
            SEQ_EMIT: begin
                if (req_ready && req.last) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        req_valid = 1'b0;
        case (state_reg)
            SEQ_IDLE: s_tready = 1'b1;
            SEQ_EMIT: req_valid = 1'b1;
            default: begin
                s_tready = 1'b0;
                req_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            bidx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                bidx_reg <= '0;
            end else if (req_valid && req_ready) begin
                bidx_reg <= bidx_reg + BIDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg <= opcode_t'(s_tdata[1:0]);
            byte_reg <= s_tdata[9:2];
        end
    end

    clcd_beat_gen u_beat_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .backlight(backlight_reg),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the character-LCD sequencer: it predicts each expander beat.
`default_nettype none
module tb_top;
    import clcd_pkg::*;

    localparam int DIGITS = DEF_READING_DIGITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 38;

    localparam logic [7:0] INIT_SEQ [INIT_CMDS] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};
    localparam logic [7:0] LABEL [5] = '{8'h47, 8'h41, 8'h53, 8'h3A, 8'h20};
    localparam int PCT_CHOICE [3] = '{0, 15, 50};

    typedef struct packed {
        logic [7:0] code;
        logic [1:0] pause;
        logic       last;
    } expander_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    expander_beat_t beats_due[$];
    expander_beat_t beat_seen;
    logic           backlight_model = 1'b1;
    int             errors = 0;
    int             cycles = 0;
    int             gap_pct = 0;
    int             stall_pct = 0;

    char_lcd_4bit_i2c_sequencer_top #(
        .READING_DIGITS(DIGITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (beats_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got byte %h pause %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                beat_seen = beats_due.pop_front();
                if (m_tdata !== beat_seen.code) begin
                    $display("%0t: expander byte mismatch, expected %h, got %h",
                             $time, beat_seen.code, m_tdata);
                    errors++;
                end
                if (m_tuser !== beat_seen.pause) begin
                    $display("%0t: pause class mismatch, expected %0d, got %0d",
                             $time, beat_seen.pause, m_tuser);
                    errors++;
                end
                if (m_tlast !== beat_seen.last) begin
                    $display("%0t: last flag mismatch, expected %0b, got %0b",
                             $time, beat_seen.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic void push_lcd_byte(logic [7:0] v, logic is_data, logic [1:0] end_pause);
        logic [7:0] base;
        logic [7:0] hi;
        logic [7:0] lo;
        base = (backlight_model ? BIT_BACKLIGHT : 8'h00) | (is_data ? BIT_SELECT : 8'h00);
        hi = (v & NIBBLE_MASK) | base;
        lo = {v[3:0], 4'h0} | base;
        beats_due.push_back('{hi | BIT_ENABLE, PAUSE_SHORT, 1'b0});
        beats_due.push_back('{hi, PAUSE_SHORT, 1'b0});
        beats_due.push_back('{lo | BIT_ENABLE, PAUSE_SHORT, 1'b0});
        beats_due.push_back('{lo, end_pause, 1'b0});
    endfunction

    function automatic void predict_expander_beats(opcode_t op, logic [7:0] bv, logic [15:0] rd);
        logic [7:0]  digits[$];
        int unsigned v;
        v = rd;
        case (op)
            OP_CMD:  push_lcd_byte(bv, 1'b0, PAUSE_CHAR);
            OP_DATA: push_lcd_byte(bv, 1'b1, PAUSE_CHAR);
            OP_INIT: begin
                for (int i = 0; i < INIT_CMDS; i++)
                    push_lcd_byte(INIT_SEQ[i], 1'b0, (i == INIT_CMDS - 1) ? PAUSE_CLEAR : PAUSE_CHAR);
            end
            default: begin
                push_lcd_byte(CMD_LINE1, 1'b0, PAUSE_CHAR);
                foreach (LABEL[i])
                    push_lcd_byte(LABEL[i], 1'b1, PAUSE_CHAR);
                if (v == 0)
                    digits.push_front(CHAR_ZERO);
                while (v > 0 && digits.size() < DIGITS) begin
                    digits.push_front(CHAR_ZERO + 8'(v % 10));
                    v = v / 10;
                end
                foreach (digits[i])
                    push_lcd_byte(digits[i], 1'b1, PAUSE_CHAR);
            end
        endcase
        beats_due[$].last = 1'b1;
    endfunction

    task automatic send_request(opcode_t op, logic [7:0] bv, logic [15:0] rd);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, rd, bv, op};
        do @(posedge aclk); while (!s_tready);
        predict_expander_beats(op, bv, rd);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] wd,
                              output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wd;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_backlight(logic [31:0] wd);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, ADDR_BACKLIGHT, wd, rd);
        backlight_model = wd[0];
        apb_access(1'b0, ADDR_BACKLIGHT, '0, rd);
        if (rd !== {31'd0, backlight_model}) begin
            $display("%0t: backlight read-back mismatch, expected %h, got %h",
                     $time, {31'd0, backlight_model}, rd);
            errors++;
        end
    endtask

    function automatic logic [15:0] random_reading();
        int unsigned n;
        int unsigned lo_v;
        int unsigned hi_v;
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 65535));
            default: begin
                n = $urandom_range(1, 5);
                lo_v = (n == 1) ? 1 : 10 ** (n - 1);
                hi_v = (10 ** n) - 1;
                if (hi_v > 65535)
                    hi_v = 65535;
                return 16'($urandom_range(lo_v, hi_v));
            end
        endcase
    endfunction

    task automatic test_directed_ops();
        send_request(OP_CMD, 8'h00, 16'hFFFF);
        send_request(OP_CMD, 8'hFF, 16'h0000);
        send_request(OP_DATA, 8'h00, 16'hFFFF);
        send_request(OP_DATA, 8'hFF, 16'h0000);
        send_request(OP_CMD, 8'h01, 16'h1234);
        send_request(OP_DATA, 8'h5A, 16'(16'($urandom)));
        send_request(OP_INIT, 8'h00, 16'h0000);
        send_request(OP_INIT, 8'hFF, 16'hFFFF);
        send_request(OP_READING, 8'hFF, 16'd0);
        send_request(OP_READING, 8'h00, 16'd9);
        send_request(OP_READING, 8'($urandom), 16'd10);
        send_request(OP_READING, 8'($urandom), 16'd10000);
        send_request(OP_READING, 8'($urandom), 16'd40506);
        send_request(OP_READING, 8'($urandom), 16'd65535);
    endtask

    task automatic test_backlight_off();
        write_backlight(32'h0000_0000);
        send_request(OP_CMD, 8'hA5, 16'd0);
        send_request(OP_DATA, 8'h3C, 16'd0);
        send_request(OP_INIT, 8'h00, 16'd0);
        send_request(OP_READING, 8'h00, 16'd12345);
        send_request(OP_READING, 8'h00, 16'd0);
        write_backlight(32'hFFFF_FFFF);
        send_request(OP_DATA, 8'hC3, 16'd0);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++) begin
            write_backlight({31'($urandom), (p < 2) ? p[0] : 1'($urandom)});
            if (p == PHASES - 1) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = PCT_CHOICE[$urandom_range(0, 2)];
                stall_pct = PCT_CHOICE[$urandom_range(0, 2)];
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_request(opcode_t'($urandom_range(0, 3)), 8'($urandom), random_reading());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ops();
        test_backlight_off();
        test_random_traffic();
        wait_drained();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
